// ----- src/ktli_pkg.sv -----
// ----------------------------------------------------------------------------
// ktli_pkg
// Shared types and constants of the keyed table linear interpolator.
// ----------------------------------------------------------------------------
package ktli_pkg;

	localparam int ACT_W    = 2;
	localparam int MAT_W    = 6;
	localparam int TEMP_W   = 11;
	localparam int VAL_W    = 26;
	localparam int NUM_VALS = 6;
	localparam int SEL_W    = 3;
	// bracket distance: brackets and query are all 11-bit signed, with lo <= t <= up
	localparam int DIFF_W   = 11;

	typedef enum logic [ACT_W-1:0] {
		ACT_CLEAR = 2'd0,
		ACT_LOAD  = 2'd1,
		ACT_QUERY = 2'd2
	} act_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_END,
		ST_RD_LO,
		ST_RD_UP,
		ST_LATCH,
		ST_DIV,
		ST_MUL,
		ST_ADD,
		ST_OUT
	} ctrl_state_t;

	typedef logic [NUM_VALS-1:0][VAL_W-1:0] vals_t;

	typedef struct packed {
		logic [MAT_W-1:0]         material;
		logic signed [TEMP_W-1:0] temperature;
		vals_t                    vals;
	} row_t;

	typedef struct packed {
		logic             clear;
		logic             load;
		logic             start;
		logic             scan_rd;
		logic             rd_lo;
		logic             rd_up;
		logic             lat_lo;
		logic             lat_up;
		logic             div_step;
		logic             mul;
		logic             add;
		logic             out_load;
		logic [SEL_W-1:0] val_sel;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic scan_last;
		logic bracket_ok;
		logic eq;
		logic div_last;
	} status_t;

endpackage

// ----- src/ktli_in_if.sv -----
// ----------------------------------------------------------------------------
// ktli_in_if
// Input channel: one table command word (clear, load row, query).
// ----------------------------------------------------------------------------
interface ktli_in_if import ktli_pkg::*; ();

	logic                     valid;
	logic                     ready;
	logic [ACT_W-1:0]         action;
	logic [MAT_W-1:0]         material;
	logic signed [TEMP_W-1:0] temperature;
	logic [VAL_W-1:0]         in_min_stress;
	logic [VAL_W-1:0]         in_max_stress;
	logic [VAL_W-1:0]         in_modulus;
	logic [VAL_W-1:0]         in_modulus_slope;
	logic [VAL_W-1:0]         in_factor_m;
	logic [VAL_W-1:0]         in_creep;

	modport source (
		output valid, action, material, temperature, in_min_stress, in_max_stress,
			in_modulus, in_modulus_slope, in_factor_m, in_creep,
		input  ready
	);

	modport sink (
		input  valid, action, material, temperature, in_min_stress, in_max_stress,
			in_modulus, in_modulus_slope, in_factor_m, in_creep,
		output ready
	);

endinterface

// ----- src/ktli_out_if.sv -----
// ----------------------------------------------------------------------------
// ktli_out_if
// Output channel: one interpolated property word per query.
// ----------------------------------------------------------------------------
interface ktli_out_if import ktli_pkg::*; ();

	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] out_min_stress;
	logic [VAL_W-1:0] out_max_stress;
	logic [VAL_W-1:0] out_modulus;
	logic [VAL_W-1:0] out_modulus_slope;
	logic [VAL_W-1:0] out_factor_m;
	logic [VAL_W-1:0] out_creep;
	logic             out_of_range;

	modport source (
		output valid, out_min_stress, out_max_stress, out_modulus, out_modulus_slope,
			out_factor_m, out_creep, out_of_range,
		input  ready
	);

	modport sink (
		input  valid, out_min_stress, out_max_stress, out_modulus, out_modulus_slope,
			out_factor_m, out_creep, out_of_range,
		output ready
	);

endinterface

// ----- src/ktli_ctrl.sv -----
// ----------------------------------------------------------------------------
// ktli_ctrl
// Sequencer: table scan, bracket fetch, serial divide, shared multiply loop.
// ----------------------------------------------------------------------------
module ktli_ctrl import ktli_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [ACT_W-1:0] in_action,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  status_t          status,
	output cmd_t             cmd
);

	ctrl_state_t      state_q, state_d;
	logic [SEL_W-1:0] k_q, k_d;
	logic             out_valid_q, out_valid_d;
	logic             in_acc;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			k_q         <= k_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		k_d         = k_q;
		cmd         = '0;
		cmd.val_sel = k_q;
		out_valid_d = out_valid_q && !out_ready;

		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (in_action)
						ACT_CLEAR: cmd.clear = 1'b1;
						ACT_LOAD:  cmd.load  = 1'b1;
						ACT_QUERY: begin
							cmd.start = 1'b1;
							k_d       = '0;
							state_d   = status.empty ? ST_SCAN_END : ST_SCAN;
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (status.scan_last)
					state_d = ST_SCAN_END;
			end
			// last row compare lands here
			ST_SCAN_END: state_d = ST_RD_LO;
			ST_RD_LO: begin
				if (status.bracket_ok) begin
					cmd.rd_lo = 1'b1;
					state_d   = ST_RD_UP;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_RD_UP: begin
				cmd.rd_up  = 1'b1;
				cmd.lat_lo = 1'b1;
				state_d    = ST_LATCH;
			end
			ST_LATCH: begin
				cmd.lat_up = 1'b1;
				state_d    = status.eq ? ST_MUL : ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last)
					state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ADD;
			end
			ST_ADD: begin
				cmd.add = 1'b1;
				if (k_q == SEL_W'(NUM_VALS - 1)) begin
					k_d     = '0;
					state_d = ST_OUT;
				end else begin
					k_d     = k_q + SEL_W'(1);
					state_d = ST_MUL;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	a_out_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result loaded over an unsent word");
	a_sel_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mul || cmd.add) |-> (k_q < SEL_W'(NUM_VALS)))
		else $error("value select out of range");
`endif

endmodule

// ----- src/ktli_dpath.sv -----
// ----------------------------------------------------------------------------
// ktli_dpath
// Row store, bracket search, restoring divider and shared interpolation MAC.
// ----------------------------------------------------------------------------
module ktli_dpath import ktli_pkg::*; #(
	parameter int TABLE_DEPTH   = 256,
	parameter int FRACTION_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	output status_t                  status,
	input  logic [MAT_W-1:0]         material,
	input  logic signed [TEMP_W-1:0] temperature,
	input  vals_t                    in_vals,
	output vals_t                    out_vals,
	output logic                     out_of_range
);

	localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW  = $clog2(TABLE_DEPTH + 1);
	localparam int DCW = $clog2(FRACTION_BITS);
	localparam int RW  = FRACTION_BITS + 1;
	localparam int PW  = VAL_W + FRACTION_BITS + 3;

	// row store
	row_t                     mem [TABLE_DEPTH];
	row_t                     rd_q;
	logic                     rd_en;
	logic [AW-1:0]            rd_addr;
	logic [CW-1:0]            count_q;
	logic                     full;

	// scan
	logic [CW-1:0]            scan_idx_q;
	logic [AW-1:0]            scan_idx_s1;
	logic                     scan_vld_s1;
	logic [MAT_W-1:0]         q_mat_q;
	logic signed [TEMP_W-1:0] q_temp_q;
	logic                     have_lo_q, have_up_q;
	logic [AW-1:0]            lo_idx_q, up_idx_q;
	logic signed [TEMP_W-1:0] lo_t_q, up_t_q;
	logic                     hit, take_lo, take_up;

	// divider
	logic [DIFF_W-1:0]        rem_q, den_q;
	logic [DIFF_W:0]          rem2, rem2_sub;
	logic                     ge;
	logic [TEMP_W:0]          dt, dd;
	logic [DCW-1:0]           div_cnt_q;
	logic [RW-1:0]            r_q;

	// interpolation
	row_t                     lo_row_q, up_row_q;
	logic [VAL_W-1:0]         vl, vu;
	logic signed [VAL_W:0]    diff;
	logic signed [RW:0]       r_s;
	logic signed [PW-1:0]     prod_q, prod_sh;
	logic [VAL_W:0]           sum_w;
	vals_t                    res_q;
	vals_t                    out_vals_q;
	logic                     out_of_range_q;

	assign full = (count_q == CW'(TABLE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (cmd.load && !full) begin
			count_q <= count_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && !full)
			mem[count_q[AW-1:0]] <= '{material: material, temperature: temperature,
				vals: in_vals};
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	assign rd_en = cmd.scan_rd || cmd.rd_lo || cmd.rd_up;

	always_comb begin
		rd_addr = scan_idx_q[AW-1:0];
		if (cmd.rd_lo)
			rd_addr = lo_idx_q;
		else if (cmd.rd_up)
			rd_addr = up_idx_q;
	end

	// nearest rows at or below / at or above; a later row wins a tie
	assign hit     = scan_vld_s1 && (rd_q.material == q_mat_q);
	assign take_up = hit && (rd_q.temperature >= q_temp_q)
		&& (!have_up_q || (up_t_q >= rd_q.temperature));
	assign take_lo = hit && (rd_q.temperature <= q_temp_q)
		&& (!have_lo_q || (lo_t_q <= rd_q.temperature));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_vld_s1 <= 1'b0;
			scan_idx_q  <= '0;
			have_lo_q   <= 1'b0;
			have_up_q   <= 1'b0;
		end else begin
			scan_vld_s1 <= cmd.scan_rd;
			if (cmd.start) begin
				scan_idx_q <= '0;
				have_lo_q  <= 1'b0;
				have_up_q  <= 1'b0;
			end else begin
				if (cmd.scan_rd)
					scan_idx_q <= scan_idx_q + CW'(1);
				if (take_lo)
					have_lo_q <= 1'b1;
				if (take_up)
					have_up_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		scan_idx_s1 <= scan_idx_q[AW-1:0];
		if (cmd.start) begin
			q_mat_q  <= material;
			q_temp_q <= temperature;
		end
		if (take_lo) begin
			lo_idx_q <= scan_idx_s1;
			lo_t_q   <= rd_q.temperature;
		end
		if (take_up) begin
			up_idx_q <= scan_idx_s1;
			up_t_q   <= rd_q.temperature;
		end
		if (cmd.lat_lo)
			lo_row_q <= rd_q;
		if (cmd.lat_up)
			up_row_q <= rd_q;
	end

	// restoring divide, one quotient bit a cycle; remainder never exceeds den
	assign dt       = {q_temp_q[TEMP_W-1], q_temp_q} - {lo_t_q[TEMP_W-1], lo_t_q};
	assign dd       = {up_t_q[TEMP_W-1], up_t_q} - {lo_t_q[TEMP_W-1], lo_t_q};
	assign rem2     = {rem_q, 1'b0};
	assign rem2_sub = rem2 - {1'b0, den_q};
	assign ge       = (rem2 >= {1'b0, den_q});

	always_ff @(posedge clk) begin
		if (cmd.lat_up) begin
			rem_q     <= dt[DIFF_W-1:0];
			den_q     <= dd[DIFF_W-1:0];
			div_cnt_q <= '0;
			// equal brackets: full weight on the upper row
			r_q       <= status.eq ? RW'(1) << FRACTION_BITS : '0;
		end else if (cmd.div_step) begin
			rem_q     <= ge ? rem2_sub[DIFF_W-1:0] : rem2[DIFF_W-1:0];
			div_cnt_q <= div_cnt_q + DCW'(1);
			r_q       <= {r_q[RW-2:0], ge};
		end
	end

	// vl + floor((vu - vl) * r / 2^F), one value per multiply and add step
	assign vl      = lo_row_q.vals[cmd.val_sel];
	assign vu      = up_row_q.vals[cmd.val_sel];
	assign diff    = $signed({1'b0, vu}) - $signed({1'b0, vl});
	assign r_s     = $signed({1'b0, r_q});
	assign prod_sh = prod_q >>> FRACTION_BITS;
	assign sum_w   = {1'b0, vl} + prod_sh[VAL_W:0];

	always_ff @(posedge clk) begin
		if (cmd.mul)
			prod_q <= diff * r_s;
		if (cmd.add)
			res_q[cmd.val_sel] <= sum_w[VAL_W-1:0];
		if (cmd.out_load) begin
			out_vals_q     <= (have_lo_q && have_up_q) ? res_q : '0;
			out_of_range_q <= !(have_lo_q && have_up_q);
		end
	end

	assign out_vals     = out_vals_q;
	assign out_of_range = out_of_range_q;

	assign status.empty      = (count_q == '0);
	assign status.scan_last  = (scan_idx_q == CW'(count_q - CW'(1)));
	assign status.bracket_ok = have_lo_q && have_up_q;
	assign status.eq         = (lo_t_q == up_t_q);
	assign status.div_last   = (div_cnt_q == DCW'(FRACTION_BITS - 1));

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("row count beyond table depth");
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && !cmd.clear && full) |=> full)
		else $error("load into full table changed the count");
	a_lo_bracket: assert property (@(posedge clk) disable iff (!arst_n)
		have_lo_q |-> (lo_t_q <= q_temp_q))
		else $error("lower bracket above query temperature");
	a_up_bracket: assert property (@(posedge clk) disable iff (!arst_n)
		have_up_q |-> (up_t_q >= q_temp_q))
		else $error("upper bracket below query temperature");
`endif

endmodule

// ----- src/keyed_table_linear_interpolator.sv -----
// ----------------------------------------------------------------------------
// keyed_table_linear_interpolator
// Material/temperature keyed property table with linear interpolation.
// ----------------------------------------------------------------------------
//  channel  role    word
//  item     sink    action, material, temperature, six Q18.8 row values
//  result   source  six interpolated Q18.8 values, out_of_range
//
// Clear, load and unused actions are handled in the idle state.
// A query reads one row from the row store per cycle during the scan, then,
// unless the brackets are equal, finds one quotient bit per cycle in the
// divider, then runs a multiply and an add per value on the shared multiplier.
// Reset empties the table at once; no clearing pass.
// A finished word waits in the output register; a new word is taken meanwhile.
// ----------------------------------------------------------------------------
module keyed_table_linear_interpolator import ktli_pkg::*; #(
	parameter int TABLE_DEPTH   = 256,
	parameter int FRACTION_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	ktli_in_if.sink  item,
	ktli_out_if.source result
);

	cmd_t    cmd;
	status_t status;
	vals_t   in_vals;
	vals_t   out_vals;

	assign in_vals = {item.in_creep, item.in_factor_m, item.in_modulus_slope,
		item.in_modulus, item.in_max_stress, item.in_min_stress};

	ktli_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_action (item.action),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	ktli_dpath #(
		.TABLE_DEPTH   (TABLE_DEPTH),
		.FRACTION_BITS (FRACTION_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.material     (item.material),
		.temperature  (item.temperature),
		.in_vals      (in_vals),
		.out_vals     (out_vals),
		.out_of_range (result.out_of_range)
	);

	assign result.out_min_stress    = out_vals[0];
	assign result.out_max_stress    = out_vals[1];
	assign result.out_modulus       = out_vals[2];
	assign result.out_modulus_slope = out_vals[3];
	assign result.out_factor_m      = out_vals[4];
	assign result.out_creep         = out_vals[5];

endmodule

// ----- tb/sv/keyed_table_linear_interpolator_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_table_linear_interpolator_test
// Self-checking bench for the keyed table interpolator. Keeps a shadow copy
// of the row table, computes the expected property word for every query,
// and compares it field by field with the result channel, under random
// sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module keyed_table_linear_interpolator_test import ktli_pkg::*; ();

	localparam int DEPTH        = 256;
	localparam int FRAC         = 16;
	localparam int N_ITEMS      = 1700;
	localparam int DRAIN_CYCLES = 400;
	localparam int MAX_REPORTS  = 10;

	localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;
	localparam logic [VAL_W-1:0] VAL_MAX  = '1;

	typedef enum int {
		FLOW_FREE,
		FLOW_RANDOM,
		FLOW_SPARSE,
		FLOW_HALF
	} flow_t;

	typedef struct {
		logic [ACT_W-1:0]         action;
		logic [MAT_W-1:0]         material;
		logic signed [TEMP_W-1:0] temperature;
		vals_t                    vals;
		bit                       drain;
	} cmd_word_t;

	typedef struct {
		vals_t vals;
		logic  out_of_range;
	} prop_word_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b1;

	ktli_in_if  item_ch ();
	ktli_out_if result_ch ();

	keyed_table_linear_interpolator #(
		.TABLE_DEPTH  (DEPTH),
		.FRACTION_BITS(FRAC)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_ch),
		.result(result_ch)
	);

	// shadow of the row store
	int               rows_held;
	logic [MAT_W-1:0] row_mat  [DEPTH];
	int               row_temp [DEPTH];
	vals_t            row_vals [DEPTH];

	cmd_word_t  words_pending [$];
	prop_word_t props_due [$];
	cmd_word_t  cur_word;
	prop_word_t want;
	int         words_total;
	int         words_taken;
	int         props_seen;
	int         fail_cnt;
	int         burst_left;
	int         gap_left;
	flow_t      flow_mode;
	int         flow_left;
	int         flow_tick;

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic logic [VAL_W-1:0] rand_val();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return VAL_MAX;
			default: return VAL_W'($urandom());
		endcase
	endfunction

	function automatic int rand_temp();
		case ($urandom_range(0, 7))
			0: return -1024;
			1: return 1023;
			default: return int'($urandom_range(0, 2047)) - 1024;
		endcase
	endfunction

	function automatic cmd_word_t make_word(input logic [ACT_W-1:0] act,
			input logic [MAT_W-1:0] mat, input int temp);
		cmd_word_t w;
		w.action      = act;
		w.material    = mat;
		w.temperature = temp[TEMP_W-1:0];
		w.drain       = 1'b0;
		for (int k = 0; k < NUM_VALS; k++)
			w.vals[k] = rand_val();
		return w;
	endfunction

	task automatic queue_word(input cmd_word_t w);
		words_pending.insert(words_pending.size(), w);
	endtask

	// Update the shadow table; a query queues its interpolated property word.
	task automatic apply_to_table(input cmd_word_t w);
		prop_word_t p;
		int         t, tl, tu, lo, up, i, k;
		bit         have_lo, have_up;
		longint     r, vl, vu, v;
		case (w.action)
			ACT_CLEAR: begin
				rows_held = 0;
			end
			ACT_LOAD: begin
				if (rows_held < DEPTH) begin
					row_mat[rows_held]  = w.material;
					row_temp[rows_held] = int'(w.temperature);
					row_vals[rows_held] = w.vals;
					rows_held++;
				end
			end
			ACT_QUERY: begin
				t       = int'(w.temperature);
				have_lo = 1'b0;
				have_up = 1'b0;
				lo      = 0;
				up      = 0;
				// ties go to the later row
				for (i = 0; i < rows_held; i++) begin
					if (row_mat[i] == w.material) begin
						if (row_temp[i] >= t && (!have_up || row_temp[i] <= row_temp[up])) begin
							up      = i;
							have_up = 1'b1;
						end
						if (row_temp[i] <= t && (!have_lo || row_temp[i] >= row_temp[lo])) begin
							lo      = i;
							have_lo = 1'b1;
						end
					end
				end
				p.vals         = '0;
				p.out_of_range = 1'b1;
				if (have_lo && have_up) begin
					p.out_of_range = 1'b0;
					tl = row_temp[lo];
					tu = row_temp[up];
					if (tu == tl) begin
						p.vals = row_vals[up];
					end else begin
						r = (longint'(t - tl) <<< FRAC) / longint'(tu - tl);
						for (k = 0; k < NUM_VALS; k++) begin
							vl = longint'(row_vals[lo][k]);
							vu = longint'(row_vals[up][k]);
							// arithmetic shift floors a negative product
							v  = vl + (((vu - vl) * r) >>> FRAC);
							p.vals[k] = v[VAL_W-1:0];
						end
					end
				end
				props_due.insert(props_due.size(), p);
			end
			default: ;
		endcase
	endtask

	task automatic check_field(input string fname, input logic [VAL_W-1:0] exp_v,
			input logic [VAL_W-1:0] got_v);
		if (exp_v !== got_v) begin
			fail_cnt++;
			if (fail_cnt <= MAX_REPORTS)
				$display("word %0d: %s expected %h, got %h", props_seen, fname, exp_v, got_v);
		end
	endtask

	// sender: bursts of random length with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid            <= 1'b0;
			item_ch.action           <= ACT_CLEAR;
			item_ch.material         <= '0;
			item_ch.temperature      <= '0;
			item_ch.in_min_stress    <= '0;
			item_ch.in_max_stress    <= '0;
			item_ch.in_modulus       <= '0;
			item_ch.in_modulus_slope <= '0;
			item_ch.in_factor_m      <= '0;
			item_ch.in_creep         <= '0;
			burst_left = 1;
			gap_left   = 0;
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				apply_to_table(cur_word);
				words_taken++;
			end
			if (!item_ch.valid || item_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					item_ch.valid <= 1'b0;
				end else if (words_pending.size() != 0 &&
						!(words_pending[0].drain && props_due.size() != 0)) begin
					cur_word = words_pending.pop_front();
					item_ch.valid            <= 1'b1;
					item_ch.action           <= cur_word.action;
					item_ch.material         <= cur_word.material;
					item_ch.temperature      <= cur_word.temperature;
					item_ch.in_min_stress    <= cur_word.vals[0];
					item_ch.in_max_stress    <= cur_word.vals[1];
					item_ch.in_modulus       <= cur_word.vals[2];
					item_ch.in_modulus_slope <= cur_word.vals[3];
					item_ch.in_factor_m      <= cur_word.vals[4];
					item_ch.in_creep         <= cur_word.vals[5];
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks each word, stalls in modes of random length
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			flow_mode = FLOW_FREE;
			flow_left = 0;
			flow_tick = 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				props_seen++;
				if (props_due.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= MAX_REPORTS)
						$display("word %0d: result with nothing expected", props_seen);
				end else begin
					want = props_due.pop_front();
					check_field("min_stress", want.vals[0], result_ch.out_min_stress);
					check_field("max_stress", want.vals[1], result_ch.out_max_stress);
					check_field("modulus", want.vals[2], result_ch.out_modulus);
					check_field("modulus_slope", want.vals[3], result_ch.out_modulus_slope);
					check_field("factor_m", want.vals[4], result_ch.out_factor_m);
					check_field("creep", want.vals[5], result_ch.out_creep);
					check_field("out_of_range", VAL_W'(want.out_of_range),
						VAL_W'(result_ch.out_of_range));
				end
			end
			if (flow_left == 0) begin
				flow_mode = flow_t'($urandom_range(0, 3));
				flow_left = $urandom_range(20, 300);
			end else begin
				flow_left--;
			end
			flow_tick++;
			case (flow_mode)
				FLOW_FREE:   result_ch.ready <= 1'b1;
				FLOW_RANDOM: result_ch.ready <= ($urandom_range(0, 3) != 0);
				FLOW_SPARSE: result_ch.ready <= (flow_tick % 8 == 0);
				default:     result_ch.ready <= ($urandom_range(0, 1) == 1);
			endcase
		end
	end

	initial begin
		#10_000_000;
		$display("keyed_table_linear_interpolator_test: FAIL");
		$finish;
	end

	initial begin
		cmd_word_t        w;
		logic [MAT_W-1:0] mats [3];
		int               temps [$];
		int               n_mat, n, nq, base, span, temp, i, j;
		bit               filled;

		arst_n <= 1'b0;

		// directed
		queue_word(make_word(ACT_CLEAR, 0, 0));
		queue_word(make_word(ACT_QUERY, 0, 0));     // empty table
		w = make_word(ACT_LOAD, 5, -1024);
		w.vals = '0;
		queue_word(w);
		w = make_word(ACT_LOAD, 5, 1023);
		w.vals = '1;
		queue_word(w);
		queue_word(make_word(ACT_QUERY, 5, 0));
		queue_word(make_word(ACT_QUERY, 5, -1024));
		queue_word(make_word(ACT_QUERY, 5, 1023));
		// same temperature twice: the later row must win
		w = make_word(ACT_LOAD, 5, 100);
		w.vals = {NUM_VALS{26'h2AAAAAA}};
		queue_word(w);
		w = make_word(ACT_LOAD, 5, 100);
		w.vals = {NUM_VALS{26'h1555555}};
		queue_word(w);
		queue_word(make_word(ACT_QUERY, 5, 100));
		queue_word(make_word(ACT_QUERY, 5, 50));
		queue_word(make_word(ACT_QUERY, 5, 700));
		queue_word(make_word(ACT_QUERY, 5, 101));
		queue_word(make_word(ACT_QUERY, 63, 0));    // no rows of this key
		w = make_word(ACT_LOAD, 63, 10);
		w.vals = '1;
		queue_word(w);
		queue_word(make_word(ACT_QUERY, 63, 9));    // below all rows
		queue_word(make_word(ACT_QUERY, 63, 11));   // above all rows
		w = make_word(ACT_LOAD, 63, 20);
		w.vals = '0;
		queue_word(w);
		queue_word(make_word(ACT_QUERY, 63, 13));   // falling values
		queue_word(make_word(ACT_NONE, MAT_W'($urandom_range(0, 63)), rand_temp()));
		w = make_word(ACT_CLEAR, 0, 0);
		w.drain = 1'b1;
		queue_word(w);
		queue_word(make_word(ACT_QUERY, 5, 0));

		// random
		filled = 1'b0;
		while (words_pending.size() < N_ITEMS) begin
			if (!filled && words_pending.size() >= N_ITEMS / 2) begin
				// fill the table, then overflow it
				filled = 1'b1;
				queue_word(make_word(ACT_CLEAR, 0, 0));
				for (i = 0; i < DEPTH + 4; i++)
					queue_word(make_word(ACT_LOAD, MAT_W'($urandom_range(0, 3)), rand_temp()));
				for (i = 0; i < 10; i++)
					queue_word(make_word(ACT_QUERY, MAT_W'($urandom_range(0, 3)), rand_temp()));
			end else if ($urandom_range(0, 99) < 12) begin
				n = $urandom_range(1, 6);
				for (i = 0; i < n; i++)
					queue_word(make_word(ACT_W'($urandom_range(0, 3)),
						MAT_W'($urandom_range(0, 63)), rand_temp()));
			end else begin
				if ($urandom_range(0, 3) != 0)
					queue_word(make_word(ACT_CLEAR, MAT_W'($urandom_range(0, 63)), rand_temp()));
				n_mat = $urandom_range(1, 3);
				for (i = 0; i < 3; i++)
					mats[i] = MAT_W'($urandom_range(0, 63));
				base = int'($urandom_range(0, 2047)) - 1024;
				case ($urandom_range(0, 3))
					0: span = 4;
					1: span = 40;
					2: span = 600;
					default: span = 2047;
				endcase
				temps.delete();
				n = $urandom_range(2, 16);
				for (i = 0; i < n; i++) begin
					if (temps.size() != 0 && $urandom_range(0, 4) == 0)
						temp = temps[$urandom_range(0, temps.size() - 1)];
					else
						temp = base + int'($urandom_range(0, span)) - span / 2;
					temps.insert(temps.size(), temp);
					queue_word(make_word(ACT_LOAD, mats[$urandom_range(0, n_mat - 1)], temp));
				end
				nq = $urandom_range(2, 10);
				for (j = 0; j < nq; j++) begin
					case ($urandom_range(0, 3))
						0: temp = temps[$urandom_range(0, temps.size() - 1)];
						1: temp = temps[$urandom_range(0, temps.size() - 1)]
							+ int'($urandom_range(0, 6)) - 3;
						2: temp = base + int'($urandom_range(0, span)) - span / 2;
						default: temp = rand_temp();
					endcase
					if ($urandom_range(0, 7) == 0)
						w = make_word(ACT_QUERY, MAT_W'($urandom_range(0, 63)), temp);
					else
						w = make_word(ACT_QUERY, mats[$urandom_range(0, n_mat - 1)], temp);
					w.drain = (j == 0) && ($urandom_range(0, 19) == 0);
					queue_word(w);
				end
			end
		end
		words_total = words_pending.size();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (words_taken < words_total)
			@(posedge clk);
		while (props_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_cnt == 0) begin
			$display("keyed_table_linear_interpolator_test: PASS");
		end else begin
			$display("keyed_table_linear_interpolator_test: FAIL");
		end
		$finish;
	end

endmodule
